// File: hdl/lpht_pkg.sv
package lpht_pkg;

   localparam int FUNC_W   = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 11;
   localparam int TAG_W    = 2;

   typedef logic [FUNC_W-1:0]   func_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [TAG_W-1:0]    tag_type;

   localparam func_type FUNC_INSERT = 2'd0;
   localparam func_type FUNC_LOOKUP = 2'd1;
   localparam func_type FUNC_REMOVE = 2'd2;
   localparam func_type FUNC_CLEAR  = 2'd3;

   localparam status_type STATUS_OK          = 2'd0;
   localparam status_type STATUS_LOAD_LIMIT  = 2'd1;
   localparam status_type STATUS_FULL        = 2'd2;
   localparam status_type STATUS_KEY_MISSING = 2'd3;

   localparam tag_type TAG_EMPTY     = 2'd0;
   localparam tag_type TAG_OCCUPIED  = 2'd1;
   localparam tag_type TAG_TOMBSTONE = 2'd2;

   typedef struct packed {
      logic tag;
      logic key;
      logic value;
   } slot_wr_type;

endpackage

// File: hdl/lpht_req_if.sv
interface lpht_req_if import lpht_pkg::*; ();
   logic              valid;
   logic              ready;
   func_type          func;
   logic [DATA_W-1:0] key;
   logic [DATA_W-1:0] value;
   logic [DATA_W-1:0] default_value;

   modport source (output valid, output func, output key, output value,
                   output default_value, input ready);
   modport sink   (input valid, input func, input key, input value,
                   input default_value, output ready);
endinterface

// File: hdl/lpht_rsp_if.sv
interface lpht_rsp_if import lpht_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] result_value;
   logic              found;
   status_type        status;

   modport source (output valid, output result_value, output found, output status,
                   input ready);
   modport sink   (input valid, input result_value, input found, input status,
                   output ready);
endinterface

// File: hdl/lpht_csr_if.sv
interface lpht_csr_if import lpht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] slots_in_use;

   modport source (output valid, output slots_in_use, input ready);
   modport sink   (input valid, input slots_in_use, output ready);
endinterface

// File: hdl/lpht_mod_unit.sv
module lpht_mod_unit import lpht_pkg::*; #(
   parameter int DIVIDEND_W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [CFG_W-1:0]      divisor,
   output logic                  done,
   output logic [CFG_W-1:0]      remainder
);

   localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CFG_W-1:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [CFG_W-1:0]      divisor_ff, divisor_in;
   logic [CFG_W:0]        trial;
   logic [CFG_W:0]        diff;

   // One restoring remainder step per cycle, most significant dividend bit first.
   always_comb begin
      trial      = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(DIVIDEND_W - 1);
         rem_in     = '0;
         quot_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = (trial >= {1'b0, divisor_ff}) ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
         quot_in  = quot_ff << 1;
         count_in = count_ff - CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/lpht_slot_store.sv
module lpht_slot_store import lpht_pkg::*; #(
   parameter int DEPTH   = 1024,
   parameter int KEY_W   = 32,
   parameter int VALUE_W = 32,
   parameter int ADDR_W  = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic [ADDR_W-1:0]  rd_addr,
   output tag_type            rd_tag,
   output logic [KEY_W-1:0]   rd_key,
   output logic [VALUE_W-1:0] rd_value,
   input  slot_wr_type        wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  tag_type            wr_tag,
   input  logic [KEY_W-1:0]   wr_key,
   input  logic [VALUE_W-1:0] wr_value
);

   tag_type            tag_mem   [DEPTH];
   logic [KEY_W-1:0]   key_mem   [DEPTH];
   logic [VALUE_W-1:0] value_mem [DEPTH];

   tag_type            rd_tag_ff;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [VALUE_W-1:0] rd_value_ff;

   always_ff @(posedge clock) begin
      rd_tag_ff <= tag_mem[rd_addr];
      if (wr_en.tag) begin
         tag_mem[wr_addr] <= wr_tag;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      if (wr_en.key) begin
         key_mem[wr_addr] <= wr_key;
      end
   end

   always_ff @(posedge clock) begin
      rd_value_ff <= value_mem[rd_addr];
      if (wr_en.value) begin
         value_mem[wr_addr] <= wr_value;
      end
   end

   assign rd_tag   = rd_tag_ff;
   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

// File: hdl/linear_probe_hash_table.sv
// Channel  Port    Direction  Carries
// request  req_ch  in         func, key, value, default_value
// response rsp_ch  out        result_value, found, status
// config   csr_ch  in         slots_in_use
//
// A request is accepted, its key then passes through the bit-serial remainder unit, each probed
// slot is a tag/key/value memory read, then a compare, and last the response is posted.
// A clear request and the start-up pass after reset sweep all TABLE_DEPTH tag entries, one per
// cycle, with req_ch.ready low; the configuration channel is always ready.
// The response sits in an output register, so a new request can start while it is waiting;
// the next response then holds req_ch.ready low until that register is free.
module linear_probe_hash_table import lpht_pkg::*; #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_WIDTH   = 32,
   parameter int VALUE_WIDTH = 32
) (
   input logic        clock,
   input logic        reset,
   lpht_req_if.sink   req_ch,
   lpht_rsp_if.source rsp_ch,
   lpht_csr_if.sink   csr_ch
);

   localparam int KW     = (KEY_WIDTH > DATA_W) ? DATA_W : KEY_WIDTH;
   localparam int VW     = (VALUE_WIDTH > DATA_W) ? DATA_W : VALUE_WIDTH;
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int SLOT_MAX   = (1 << CFG_W) - 1;
   localparam int RESET_SLOTS = (TABLE_DEPTH > SLOT_MAX) ? SLOT_MAX : TABLE_DEPTH;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [CFG_W-1:0]  slots_ff, slots_in;
   logic [CFG_W-1:0]  cap_ff, cap_in;
   logic [CFG_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  sweep_ff, sweep_in;
   logic              clear_op_ff, clear_op_in;
   func_type          func_ff, func_in;
   logic [KW-1:0]     key_ff, key_in;
   logic [VW-1:0]     value_ff, value_in;
   logic [DATA_W-1:0] dflt_ff, dflt_in;
   logic [CFG_W-1:0]  pos_ff, pos_in;
   logic [CFG_W-1:0]  visit_ff, visit_in;
   logic [CFG_W-1:0]  free_ff, free_in;
   logic              has_free_ff, has_free_in;
   logic [DATA_W-1:0] res_value_ff, res_value_in;
   logic              res_found_ff, res_found_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_found_ff, rsp_found_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              req_accept;
   logic [CFG_W-1:0]  cap_now;
   logic              mod_start;
   logic              mod_done;
   logic [CFG_W-1:0]  mod_rem;
   tag_type           rd_tag;
   logic [KW-1:0]     rd_key;
   logic [VW-1:0]     rd_value;
   slot_wr_type       wr_en;
   logic [IDX_W-1:0]  wr_addr;
   tag_type           wr_tag;
   logic              hit;
   logic              is_empty;
   logic              last_probe;
   logic              has_free_now;
   logic [CFG_W-1:0]  free_now;
   logic [CFG_W+1:0]  load_limit;

   function automatic logic [CFG_W-1:0] next_pos(input logic [CFG_W-1:0] p,
                                                 input logic [CFG_W-1:0] cap);
      return (p == cap - CFG_W'(1)) ? '0 : p + CFG_W'(1);
   endfunction

   assign req_ch.ready  = (state_ff == S_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign req_accept    = req_ch.valid && req_ch.ready;
   assign mod_start     = req_accept && (req_ch.func != FUNC_CLEAR);

   always_comb begin
      if (slots_ff < CFG_W'(2)) begin
         cap_now = CFG_W'(2);
      end else if (32'(slots_ff) > TABLE_DEPTH) begin
         cap_now = CFG_W'(TABLE_DEPTH);
      end else begin
         cap_now = slots_ff;
      end
   end

   lpht_mod_unit #(
      .DIVIDEND_W (KW)
   ) u_mod_unit (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_ch.key[KW-1:0]),
      .divisor   (cap_now),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   lpht_slot_store #(
      .DEPTH   (TABLE_DEPTH),
      .KEY_W   (KW),
      .VALUE_W (VW),
      .ADDR_W  (IDX_W)
   ) u_slot_store (
      .clock    (clock),
      .rd_addr  (IDX_W'(pos_ff)),
      .rd_tag   (rd_tag),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_tag   (wr_tag),
      .wr_key   (key_ff),
      .wr_value (value_ff)
   );

   assign hit          = (rd_tag == TAG_OCCUPIED) && (rd_key == key_ff);
   assign is_empty     = (rd_tag == TAG_EMPTY);
   assign last_probe   = (visit_ff == cap_ff - CFG_W'(1));
   assign has_free_now = has_free_ff || is_empty || (rd_tag == TAG_TOMBSTONE);
   assign free_now     = has_free_ff ? free_ff : pos_ff;
   assign load_limit   = ({2'b00, cap_ff} + {1'b0, cap_ff, 1'b0}) >> 2;

   always_comb begin
      state_in      = state_ff;
      slots_in      = slots_ff;
      cap_in        = cap_ff;
      count_in      = count_ff;
      sweep_in      = sweep_ff;
      clear_op_in   = clear_op_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      dflt_in       = dflt_ff;
      pos_in        = pos_ff;
      visit_in      = visit_ff;
      free_in       = free_ff;
      has_free_in   = has_free_ff;
      res_value_in  = res_value_ff;
      res_found_in  = res_found_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = '0;
      wr_addr       = IDX_W'(pos_ff);
      wr_tag        = TAG_EMPTY;

      if (csr_ch.valid) begin
         slots_in = csr_ch.slots_in_use;
      end
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en.tag = 1'b1;
            wr_addr   = sweep_ff;
            sweep_in  = sweep_ff + IDX_W'(1);
            if (sweep_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               sweep_in    = '0;
               clear_op_in = 1'b0;
               state_in    = clear_op_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               func_in       = req_ch.func;
               key_in        = req_ch.key[KW-1:0];
               value_in      = req_ch.value[VW-1:0];
               dflt_in       = req_ch.default_value;
               cap_in        = cap_now;
               res_value_in  = '0;
               res_found_in  = 1'b0;
               res_status_in = STATUS_OK;
               if (req_ch.func == FUNC_CLEAR) begin
                  clear_op_in = 1'b1;
                  count_in    = '0;
                  state_in    = S_CLEAR;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               pos_in      = next_pos(mod_rem, cap_ff);
               visit_in    = '0;
               has_free_in = 1'b0;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (hit) begin
               res_found_in = 1'b1;
               state_in     = S_RESP;
               case (func_ff)
                  FUNC_INSERT: begin
                     wr_en.value = 1'b1;
                  end
                  FUNC_LOOKUP: begin
                     res_value_in = DATA_W'(rd_value);
                  end
                  FUNC_REMOVE: begin
                     wr_en.tag = 1'b1;
                     wr_tag    = TAG_TOMBSTONE;
                     if (count_ff != '0) begin
                        count_in = count_ff - CFG_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (is_empty || last_probe) begin
               state_in = S_RESP;
               case (func_ff)
                  FUNC_INSERT: begin
                     if (!has_free_now) begin
                        res_status_in = STATUS_FULL;
                     end else if ({2'b00, count_ff} > load_limit) begin
                        res_status_in = STATUS_LOAD_LIMIT;
                     end else begin
                        wr_en   = '1;
                        wr_addr = IDX_W'(free_now);
                        wr_tag  = TAG_OCCUPIED;
                        if (count_ff != '1) begin
                           count_in = count_ff + CFG_W'(1);
                        end
                     end
                  end
                  FUNC_LOOKUP: begin
                     res_value_in = dflt_ff;
                  end
                  FUNC_REMOVE: begin
                     res_status_in = STATUS_KEY_MISSING;
                  end
                  default: begin
                  end
               endcase
            end else begin
               has_free_in = has_free_now;
               free_in     = free_now;
               visit_in    = visit_ff + CFG_W'(1);
               pos_in      = next_pos(pos_ff, cap_ff);
               state_in    = S_READ;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_found_in  = res_found_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         slots_ff     <= CFG_W'(RESET_SLOTS);
         count_ff     <= '0;
         sweep_ff     <= '0;
         clear_op_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slots_ff     <= slots_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         clear_op_ff  <= clear_op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cap_ff        <= cap_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      dflt_ff       <= dflt_in;
      pos_ff        <= pos_in;
      visit_ff      <= visit_in;
      free_ff       <= free_in;
      has_free_ff   <= has_free_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.status       = rsp_status_ff;

endmodule
